// ===== sv/pmfd_pkg.sv =====
// Shared constants, types and helpers for the multitap fractional delay block.
package pmfd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 8;
  localparam int HIST_DEPTH  = 1024;
  localparam int ADDR_BITS   = $clog2(HIST_DEPTH);
  localparam int WHOLE_BITS  = 10;
  localparam int DELAY_BITS  = WHOLE_BITS + FRAC_BITS;
  localparam int OUT_BITS    = SAMPLE_BITS + 4;
  localparam int TAP_COUNT   = 5;
  localparam int TAP_IDX_BITS = $clog2(TAP_COUNT);
  localparam int READ_COUNT  = 2 * TAP_COUNT;
  localparam int CNT_BITS    = $clog2(READ_COUNT);
  localparam int FILL_BITS   = ADDR_BITS + 1;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int PROD_BITS   = DIFF_BITS + FRAC_BITS + 1;
  localparam int TAP_W       = SAMPLE_BITS + 2;
  localparam int IN_BITS     = SAMPLE_BITS + TAP_COUNT * DELAY_BITS;
  localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // largest legal delay: (HIST_DEPTH-1).0 in Q10.FRAC
  localparam logic [DELAY_BITS-1:0] DELAY_LIMIT =
    DELAY_BITS'((HIST_DEPTH - 1) << FRAC_BITS);

  // tap slots (pinna events 2..6)
  localparam logic [TAP_IDX_BITS-1:0] TAP_E2 = TAP_IDX_BITS'(0);
  localparam logic [TAP_IDX_BITS-1:0] TAP_E3 = TAP_IDX_BITS'(1);
  localparam logic [TAP_IDX_BITS-1:0] TAP_E4 = TAP_IDX_BITS'(2);
  localparam logic [TAP_IDX_BITS-1:0] TAP_E5 = TAP_IDX_BITS'(3);
  localparam logic [TAP_IDX_BITS-1:0] TAP_E6 = TAP_IDX_BITS'(4);

  typedef struct packed {
    logic [WHOLE_BITS-1:0] whole;
    logic [FRAC_BITS-1:0]  frac;
  } tap_t;

  typedef struct packed {
    tap_t [TAP_COUNT-1:0]         taps;
    logic signed [SAMPLE_BITS-1:0] sample;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // tap weight in quarter units: +2, -4, +2, -1, +1
  function automatic logic signed [OUT_BITS-1:0] weigh(
    input logic [TAP_IDX_BITS-1:0] idx,
    input logic signed [TAP_W-1:0] t
  );
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] r;
    x = OUT_BITS'(t);
    case (idx)
      TAP_E2:  r = x <<< 1;
      TAP_E3:  r = -(x <<< 2);
      TAP_E4:  r = x <<< 1;
      TAP_E5:  r = -x;
      TAP_E6:  r = x;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/pmfd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pmfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pmfd_front.sv =====
// Front end: unpacks an input beat and clamps the five tap delays.
module pmfd_front import pmfd_pkg::*; (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IN_TDATA_BITS-1:0] in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output job_t                     out_job
);

  logic [DELAY_BITS-1:0] delay [TAP_COUNT];
  logic [DELAY_BITS-1:0] clamped [TAP_COUNT];

  assign out_valid = in_valid;
  assign in_ready  = out_ready;

  always_comb begin
    out_job.sample = in_data[SAMPLE_BITS-1:0];
    for (int i = 0; i < TAP_COUNT; i++) begin
      delay[i]   = in_data[SAMPLE_BITS + i*DELAY_BITS +: DELAY_BITS];
      clamped[i] = (delay[i] > DELAY_LIMIT) ? DELAY_LIMIT : delay[i];
      out_job.taps[i].whole = clamped[i][DELAY_BITS-1:FRAC_BITS];
      out_job.taps[i].frac  = clamped[i][FRAC_BITS-1:0];
    end
  end

endmodule

// ===== sv/pmfd_queue.sv =====
// Short job queue between the front end and the tap engine.
module pmfd_queue import pmfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  job_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/pmfd_back.sv =====
// Tap engine: writes the history, reads ten ages, interpolates and sums.
module pmfd_back import pmfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  job_t                  q_job,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_BITS-1:0]   out_data
);

  state_t state;
  state_t state_next;

  job_t                         job;
  logic [CNT_BITS-1:0]          cnt;
  logic [ADDR_BITS-1:0]         wp;
  logic [FILL_BITS-1:0]         fill;

  logic                         ram_we;
  logic                         rd_issue;
  logic                         out_load;
  logic [ADDR_BITS-1:0]         raddr;
  logic [SAMPLE_BITS-1:0]       rdata;

  // read issue
  logic [TAP_IDX_BITS-1:0]      iss_tap;
  logic [FILL_BITS-1:0]         iss_age;
  logic [ADDR_BITS-1:0]         iss_age_mod;
  logic                         iss_ok;

  // read data stage
  logic                         rd_vld;
  logic [CNT_BITS-1:0]          rd_idx;
  logic                         rd_ok;
  logic [TAP_IDX_BITS-1:0]      rd_tap;
  logic signed [SAMPLE_BITS-1:0] rd_val;
  logic signed [SAMPLE_BITS-1:0] a_reg;
  logic signed [DIFF_BITS-1:0]  diff;

  // product stage
  logic                         prod_vld;
  logic signed [PROD_BITS-1:0]  prod;
  logic [TAP_IDX_BITS-1:0]      prod_tap;
  logic signed [SAMPLE_BITS-1:0] prod_a;
  logic signed [TAP_W-1:0]      tap_val;

  logic signed [OUT_BITS-1:0]   acc;

  pmfd_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(HIST_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp),
    .wdata(job.sample),
    .raddr(raddr),
    .rdata(rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (q_valid) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_READ;
      ST_READ:  if (cnt == CNT_BITS'(READ_COUNT - 1)) state_next = ST_DRAIN;
      ST_DRAIN: if (!rd_vld && !prod_vld) state_next = ST_DONE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop    = 1'b0;
    ram_we   = 1'b0;
    rd_issue = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE:  q_pop = q_valid;
      ST_WRITE: ram_we = 1'b1;
      ST_READ:  rd_issue = 1'b1;
      ST_DONE:  out_load = !out_valid || out_ready;
      default:  ;
    endcase
  end

  // even read = age floor(delay), odd read = one older
  always_comb begin
    iss_tap     = cnt[CNT_BITS-1:1];
    iss_age     = {1'b0, job.taps[iss_tap].whole} + FILL_BITS'(cnt[0]);
    iss_age_mod = iss_age[ADDR_BITS-1:0];
    raddr       = wp - iss_age_mod;
    // slots not yet written since reset read as zero
    iss_ok      = ({1'b0, iss_age_mod} <= fill);
  end

  always_comb begin
    rd_tap  = rd_idx[CNT_BITS-1:1];
    rd_val  = rd_ok ? $signed(rdata) : '0;
    diff    = DIFF_BITS'(rd_val) - DIFF_BITS'(a_reg);
    tap_val = TAP_W'(prod_a) + TAP_W'(prod >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
    if (rd_issue) begin
      rd_idx <= cnt;
      rd_ok  <= iss_ok;
    end
    if (rd_vld) begin
      if (!rd_idx[0]) begin
        a_reg <= rd_val;
      end else begin
        prod     <= PROD_BITS'($signed({1'b0, job.taps[rd_tap].frac})) * PROD_BITS'(diff);
        prod_tap <= rd_tap;
        prod_a   <= a_reg;
      end
    end
    if (ram_we) begin
      acc <= OUT_BITS'(job.sample) <<< 2;
    end else if (prod_vld) begin
      acc <= acc + weigh(prod_tap, tap_val);
    end
    if (out_load) begin
      out_data <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      wp        <= '0;
      fill      <= '0;
      rd_vld    <= 1'b0;
      prod_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= rd_issue;
      prod_vld <= rd_vld && rd_idx[0];
      if (rd_issue) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        wp        <= wp + 1'b1;
        if (fill != FILL_BITS'(HIST_DEPTH)) begin
          fill <= fill + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_BITS'(HIST_DEPTH))
    else $error("history fill count past depth");

  a_wp_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill < FILL_BITS'(HIST_DEPTH)) |-> (wp == fill[ADDR_BITS-1:0]))
    else $error("write pointer out of step with fill count");

  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (!rd_vld && !prod_vld))
    else $error("result loaded with taps in flight");

  a_write_then_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |=> (state == ST_READ && cnt == '0))
    else $error("read sweep did not start after history write");

endmodule

// ===== sv/pinna_multitap_fractional_delay_top.sv =====
// Top level of the pinna multitap fractional delay line.
//
//  group   dir  tdata fields (low bit up)                          tuser/tlast
//  s_axis  in   sample_in[23:0], tap2..tap6_delay 18b each, pad 6  none
//  m_axis  out  sample_out[27:0], pad 4                            none
//
// One beat in gives one beat out. Per item the engine pops the queue,
// writes the history, issues ten reads through the single history RAM
// read port, drains interpolation and loads the output register before it
// pops the next item. The front and a two-entry queue keep taking beats
// while the engine works or the output is stalled, until the queue is
// full. Synchronous rst clears control and empties the history logically
// through a fill count (no clearing pass); unwritten ages read as zero.
module pinna_multitap_fractional_delay_top import pmfd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // sample_in[23:0], tap2_delay, tap3_delay, tap4_delay, tap5_delay,
  // tap6_delay (18b each, Q10.8), zero pad
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // sample_out[27:0] (quarter-LSB units), zero pad
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

  job_t                front_job;
  logic                front_valid;
  logic                front_ready;
  job_t                q_job;
  logic                q_valid;
  logic                q_pop;
  logic [OUT_BITS-1:0] sample_out;

  pmfd_front u_front (
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .out_valid(front_valid),
    .out_ready(front_ready),
    .out_job  (front_job)
  );

  pmfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(front_valid),
    .push_ready(front_ready),
    .push_job  (front_job),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_job   (q_job)
  );

  pmfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_job    (q_job),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (sample_out)
  );

  assign m_axis_tdata = OUT_TDATA_BITS'(sample_out);

endmodule

// ===== tb/sv/pinna_multitap_fractional_delay_top_tb.sv =====
// Self-checking testbench for the pinna multitap fractional delay top level.
module pinna_multitap_fractional_delay_top_tb import pmfd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [DELAY_BITS-1:0]         DELAY_MAX  = '1;
  // beats per random phase, four phases
  localparam int PHASE_BEATS = 338;
  // cycles with no beat on either side before the run is called hung
  localparam int IDLE_LIMIT = 4000;
  // settle time after the last result: engine pass plus queue slack
  localparam int TAIL_CYCLES = 64;

  // Predicts the weighted tap sum of every accepted beat and checks the
  // results against it in order.
  class pinna_sum_model;
    logic signed [SAMPLE_BITS-1:0] hist [HIST_DEPTH];
    logic [ADDR_BITS-1:0]          wr_ptr;
    logic signed [OUT_BITS-1:0]    expected_sums [$];
    int                            mismatch_count;

    function new();
      foreach (hist[i]) hist[i] = '0;
      wr_ptr         = '0;
      mismatch_count = 0;
    endfunction

    // interpolated tap, ages wrap modulo the history depth
    function longint tap_at(tap_t d);
      tap_t                 c;
      logic [ADDR_BITS-1:0] ia;
      logic [ADDR_BITS-1:0] ib;
      longint               a;
      longint               b;
      longint               p;
      c  = (d > DELAY_LIMIT) ? tap_t'(DELAY_LIMIT) : d;
      ia = wr_ptr - ADDR_BITS'(c.whole);
      ib = ia - 1'b1;
      a  = hist[ia];
      b  = hist[ib];
      p  = longint'(c.frac) * (b - a);
      return a + (p >>> FRAC_BITS);
    endfunction

    function void take_sample(job_t j);
      longint acc;
      hist[wr_ptr] = j.sample;
      acc = 4 * longint'(j.sample)
          + 2 * tap_at(j.taps[TAP_E2])
          - 4 * tap_at(j.taps[TAP_E3])
          + 2 * tap_at(j.taps[TAP_E4])
          -     tap_at(j.taps[TAP_E5])
          +     tap_at(j.taps[TAP_E6]);
      wr_ptr = wr_ptr + 1'b1;
      expected_sums.push_back(acc[OUT_BITS-1:0]);
    endfunction

    function void check_sum(logic [OUT_TDATA_BITS-1:0] td);
      logic signed [OUT_BITS-1:0] got;
      logic signed [OUT_BITS-1:0] want;
      got = td[OUT_BITS-1:0];
      if (expected_sums.size() == 0) begin
        $error("sample_out: expected none, got %0d", got);
        mismatch_count++;
      end else begin
        want = expected_sums.pop_front();
        if (got !== want) begin
          $error("sample_out: expected %0d, got %0d", want, got);
          mismatch_count++;
        end
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

  pinna_sum_model sums;
  int             src_idle_pct;   // chance per cycle that the source holds off
  int             snk_stall_pct;  // chance per cycle that the sink drops tready
  int             quiet_cycles;

  pinna_multitap_fractional_delay_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Sink: tready redrawn every falling edge from the current stall rate.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Monitor: results are checked before the same edge's input is noted;
  // a result can never belong to a beat taken at that very edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sums.check_sum(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sums.take_sample(job_t'(s_axis_tdata[IN_BITS-1:0]));
    end
  end

  // Watchdog: ends a run in which no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic job_t make_job(
    input logic signed [SAMPLE_BITS-1:0] s,
    input logic [DELAY_BITS-1:0] d2, d3, d4, d5, d6
  );
    job_t j;
    j.sample            = s;
    j.taps[TAP_E2]      = d2;
    j.taps[TAP_E3]      = d3;
    j.taps[TAP_E4]      = d4;
    j.taps[TAP_E5]      = d5;
    j.taps[TAP_E6]      = d6;
    return j;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [DELAY_BITS-1:0] rand_delay();
    logic [WHOLE_BITS-1:0] w;
    w = WHOLE_BITS'($urandom);
    case ($urandom_range(9))
      0:       return {WHOLE_BITS'($urandom_range(15)), FRAC_BITS'($urandom)}; // short ages
      1:       return DELAY_LIMIT;
      2:       return DELAY_BITS'($urandom_range(DELAY_MAX, DELAY_LIMIT + 1)); // clamped
      3:       return {w, {FRAC_BITS{1'b0}}};
      4:       return {w, {FRAC_BITS{1'b1}}};
      default: return DELAY_BITS'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_job(input job_t j);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_BITS'(j);
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_directed();
    // first beats: ages beyond the fill read as zero
    send_job(make_job(SAMPLE_MAX, 0, 0, 0, 0, 0));
    send_job(make_job(SAMPLE_MIN, 18'd256, 18'd128, 18'd255, 18'd1, 18'd384));
    send_job(make_job(SAMPLE_MAX, DELAY_MAX, DELAY_LIMIT, DELAY_LIMIT + 1'b1,
                      DELAY_LIMIT - 1'b1, 18'd767));
    send_job(make_job('1, 18'd1, 18'd255, 18'd511, 0, 18'd512));
    // full-scale swings with odd fractions: negative products must floor
    for (int i = 0; i < 8; i++) begin
      send_job(make_job((i % 2) ? SAMPLE_MIN : SAMPLE_MAX,
                        18'd255, 18'd1, 18'd511, 18'd129, 18'd767));
    end
    send_job(make_job('0, DELAY_MAX, DELAY_MAX, DELAY_MAX, DELAY_MAX, DELAY_MAX));
    send_job(make_job(SAMPLE_MIN, DELAY_LIMIT, DELAY_LIMIT, DELAY_LIMIT,
                      DELAY_LIMIT, DELAY_LIMIT));
    send_job(make_job(SAMPLE_MAX, 18'h2aaaa, 18'h15555, 18'h2aaaa, 18'h15555, 18'h3feff));
    for (int i = 0; i < 6; i++) begin
      send_job(make_job(rand_sample(), DELAY_BITS'(i << FRAC_BITS),
                        DELAY_BITS'((i << FRAC_BITS) | 8'hff), DELAY_BITS'(i),
                        DELAY_BITS'(((i + 1) << FRAC_BITS) | 8'h80), rand_delay()));
    end
  endtask

  initial begin
    sums          = new();
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_directed();

    // random phases: no idling, source idle, sink stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 64; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 64; end
        default: begin src_idle_pct = 22; snk_stall_pct = 22; end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_job(make_job(rand_sample(), rand_delay(), rand_delay(), rand_delay(),
                          rand_delay(), rand_delay()));
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain; the watchdog covers a result that never shows up
    while (sums.expected_sums.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sums.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pmfd_pkg.sv
sv/pmfd_ram.sv
sv/pmfd_front.sv
sv/pmfd_queue.sv
sv/pmfd_back.sv
sv/pinna_multitap_fractional_delay_top.sv
tb/sv/pinna_multitap_fractional_delay_top_tb.sv
